[rtl/mnpr_pkg.sv]
package mnpr_pkg;

  // Table sizes
  localparam int unsigned NOTE_COUNT   = 128;
  localparam int unsigned RECENT_DEPTH = 16;

  // Fixed field widths
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned OP_W   = 2;

  localparam int unsigned HELD_AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int unsigned RING_AW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2
  } op_e;

  typedef enum logic [CFG_DATA_W-1:0] {
    RT_OFF     = 2'd0,
    RT_HIGHEST = 2'd1,
    RT_LOWEST  = 2'd2,
    RT_LATEST  = 2'd3
  } retrig_e;

  typedef enum logic [CFG_DATA_W-1:0] {
    TRIG_PULSE = 2'd0,
    TRIG_GATE  = 2'd1,
    TRIG_NONE  = 2'd2
  } trig_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RING_RD,
    ST_RING_CHK,
    ST_VEL,
    ST_DELIVER
  } st_e;

  typedef struct packed {
    logic               en;
    logic [HELD_AW-1:0] addr;
    logic [VEL_W-1:0]   data;
  } held_wr_t;

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [NOTE_W-1:0]  data;
  } ring_wr_t;

  typedef struct packed {
    logic              sounds;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              fire_trigger;
    logic              gate_high;
    logic              gate_low;
  } res_t;

  function automatic logic in_table(input logic [NOTE_W-1:0] note);
    return (NOTE_W+1)'(note) < (NOTE_W+1)'(NOTE_COUNT);
  endfunction

  function automatic res_t start_result(input logic [NOTE_W-1:0] note,
                                        input logic [VEL_W-1:0] vel,
                                        input trig_e trig);
    res_t r;
    r.sounds       = 1'b1;
    r.note         = note;
    r.velocity     = vel;
    r.fire_trigger = (trig == TRIG_PULSE);
    r.gate_high    = (trig == TRIG_GATE);
    r.gate_low     = 1'b0;
    return r;
  endfunction

  function automatic res_t none_result(input trig_e trig);
    res_t r;
    r          = '0;
    r.gate_low = (trig == TRIG_GATE);
    return r;
  endfunction

endpackage

[rtl/mnpr_held_mem.sv]
module mnpr_held_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mnpr_pkg::held_wr_t            wr_i,
  input  logic                          clear_all_i,
  input  logic [mnpr_pkg::HELD_AW-1:0]  raddr_i,
  output logic                          held_o,
  output logic [mnpr_pkg::VEL_W-1:0]    rdata_o
);

  logic [mnpr_pkg::VEL_W-1:0]      mem [mnpr_pkg::NOTE_COUNT];
  logic [mnpr_pkg::VEL_W-1:0]      rdata_q;
  logic [mnpr_pkg::NOTE_COUNT-1:0] held_q;

  // velocity store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  // held flags: set by a nonzero write, cleared all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (clear_all_i) begin
      held_q <= '0;
    end else if (wr_i.en) begin
      held_q[wr_i.addr] <= (wr_i.data != '0);
    end
  end

  assign held_o  = held_q[raddr_i];
  assign rdata_o = rdata_q;

endmodule

[rtl/mnpr_ring_mem.sv]
module mnpr_ring_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mnpr_pkg::ring_wr_t            wr_i,
  input  logic [mnpr_pkg::RING_AW-1:0]  raddr_i,
  output logic [mnpr_pkg::NOTE_W-1:0]   rdata_o
);

  logic [mnpr_pkg::NOTE_W-1:0]       mem [mnpr_pkg::RECENT_DEPTH];
  logic [mnpr_pkg::NOTE_W-1:0]       rdata_q;
  logic [mnpr_pkg::RECENT_DEPTH-1:0] written_q;
  logic                              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  // unwritten slots read as note zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      rvalid_q <= written_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[rtl/mnpr_ctrl.sv]
module mnpr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mnpr_pkg::OP_W-1:0]     op_i,
  input  logic [mnpr_pkg::NOTE_W-1:0]   note_number_i,
  input  logic [mnpr_pkg::VEL_W-1:0]    note_velocity_i,
  input  mnpr_pkg::retrig_e             retrig_i,
  input  mnpr_pkg::trig_e               trig_i,
  output mnpr_pkg::held_wr_t            held_wr_o,
  output logic                          held_clear_o,
  output logic [mnpr_pkg::HELD_AW-1:0]  held_raddr_o,
  input  logic                          held_i,
  input  logic [mnpr_pkg::VEL_W-1:0]    held_rdata_i,
  output mnpr_pkg::ring_wr_t            ring_wr_o,
  output logic [mnpr_pkg::RING_AW-1:0]  ring_raddr_o,
  input  logic [mnpr_pkg::NOTE_W-1:0]   ring_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mnpr_pkg::res_t                res_o
);

  mnpr_pkg::st_e                state_q, state_d;
  logic [mnpr_pkg::HELD_AW-1:0] idx_q, idx_d;
  logic [mnpr_pkg::RING_AW-1:0] slot_q, slot_d;
  logic [mnpr_pkg::RING_AW-1:0] cnt_q, cnt_d;
  logic [mnpr_pkg::RING_AW-1:0] wp_q, wp_d;
  logic [mnpr_pkg::NOTE_W-1:0]  found_q, found_d;
  mnpr_pkg::res_t               res_q, res_d;
  mnpr_pkg::res_t               out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  mnpr_pkg::op_e op;
  logic          acc;
  logic          hit;
  logic          scan_last;
  logic          ring_last;
  logic          deliver_go;

  assign op         = mnpr_pkg::op_e'(op_i);
  assign in_ready_o = (state_q == mnpr_pkg::ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  assign scan_last = (retrig_i == mnpr_pkg::RT_HIGHEST) ?
                     (idx_q == '0) :
                     (idx_q == mnpr_pkg::HELD_AW'(mnpr_pkg::NOTE_COUNT - 1));
  assign ring_last = (cnt_q == mnpr_pkg::RING_AW'(mnpr_pkg::RECENT_DEPTH - 1));

  // held lookup follows the scan index or the ring entry under test
  assign held_raddr_o = (state_q == mnpr_pkg::ST_SCAN) ? idx_q
                                             : ring_data_i[mnpr_pkg::HELD_AW-1:0];
  assign hit = (state_q == mnpr_pkg::ST_SCAN) ? held_i :
               ((state_q == mnpr_pkg::ST_RING_CHK) && mnpr_pkg::in_table(ring_data_i) &&
                held_i);
  assign ring_raddr_o = slot_q;

  assign deliver_go = (state_q == mnpr_pkg::ST_DELIVER) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnpr_pkg::ST_IDLE: begin
        if (acc) begin
          if (op == mnpr_pkg::OP_NOTE_OFF) begin
            if (retrig_i == mnpr_pkg::RT_HIGHEST || retrig_i == mnpr_pkg::RT_LOWEST) begin
              state_d = mnpr_pkg::ST_SCAN;
            end else begin
              state_d = mnpr_pkg::ST_RING_RD;
            end
          end else begin
            state_d = mnpr_pkg::ST_DELIVER;
          end
        end
      end
      mnpr_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = mnpr_pkg::ST_VEL;
        end else if (scan_last) begin
          state_d = mnpr_pkg::ST_DELIVER;
        end
      end
      mnpr_pkg::ST_RING_RD: state_d = mnpr_pkg::ST_RING_CHK;
      mnpr_pkg::ST_RING_CHK: begin
        if (hit) begin
          state_d = mnpr_pkg::ST_VEL;
        end else if (ring_last) begin
          state_d = mnpr_pkg::ST_DELIVER;
        end else begin
          state_d = mnpr_pkg::ST_RING_RD;
        end
      end
      mnpr_pkg::ST_VEL: state_d = mnpr_pkg::ST_DELIVER;
      mnpr_pkg::ST_DELIVER: begin
        if (deliver_go) begin
          state_d = mnpr_pkg::ST_IDLE;
        end
      end
      default: state_d = mnpr_pkg::ST_IDLE;
    endcase
  end

  // outputs towards the memories
  always_comb begin
    held_wr_o         = '0;
    held_clear_o      = 1'b0;
    ring_wr_o         = '0;
    if (acc) begin
      // writes land before any search read, so no forwarding is needed
      if ((op == mnpr_pkg::OP_NOTE_ON || op == mnpr_pkg::OP_NOTE_OFF) &&
          mnpr_pkg::in_table(note_number_i)) begin
        held_wr_o.en   = 1'b1;
        held_wr_o.addr = note_number_i[mnpr_pkg::HELD_AW-1:0];
        held_wr_o.data = (op == mnpr_pkg::OP_NOTE_ON) ? note_velocity_i : '0;
      end
      held_clear_o = (op == mnpr_pkg::OP_ALL_OFF);
      if (op == mnpr_pkg::OP_NOTE_ON) begin
        ring_wr_o.en   = 1'b1;
        ring_wr_o.addr = wp_q;
        ring_wr_o.data = note_number_i;
      end
    end
  end

  // datapath registers
  always_comb begin
    idx_d   = idx_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    wp_d    = wp_q;
    found_d = found_q;
    res_d   = res_q;
    unique case (state_q)
      mnpr_pkg::ST_IDLE: begin
        if (acc) begin
          idx_d  = (retrig_i == mnpr_pkg::RT_HIGHEST) ?
                   mnpr_pkg::HELD_AW'(mnpr_pkg::NOTE_COUNT - 1) : '0;
          slot_d = (wp_q == '0) ? mnpr_pkg::RING_AW'(mnpr_pkg::RECENT_DEPTH - 1)
                                : wp_q - 1'b1;
          cnt_d  = '0;
          res_d  = '0;
          if (op == mnpr_pkg::OP_NOTE_ON) begin
            res_d = mnpr_pkg::start_result(note_number_i, note_velocity_i, trig_i);
            wp_d  = (wp_q == mnpr_pkg::RING_AW'(mnpr_pkg::RECENT_DEPTH - 1)) ?
                    '0 : wp_q + 1'b1;
          end
        end
      end
      mnpr_pkg::ST_SCAN: begin
        if (hit) begin
          found_d = mnpr_pkg::NOTE_W'(idx_q);
        end else if (scan_last) begin
          res_d = mnpr_pkg::none_result(trig_i);
        end else if (retrig_i == mnpr_pkg::RT_HIGHEST) begin
          idx_d = idx_q - 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      mnpr_pkg::ST_RING_CHK: begin
        if (hit) begin
          found_d = ring_data_i;
        end else if (ring_last) begin
          res_d = mnpr_pkg::none_result(trig_i);
        end else begin
          slot_d = (slot_q == '0) ? mnpr_pkg::RING_AW'(mnpr_pkg::RECENT_DEPTH - 1)
                                  : slot_q - 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      mnpr_pkg::ST_VEL: begin
        res_d = (retrig_i != mnpr_pkg::RT_OFF) ?
                mnpr_pkg::start_result(found_q, held_rdata_i, trig_i) : '0;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (deliver_go) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mnpr_pkg::ST_IDLE;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    cnt_q   <= cnt_d;
    found_q <= found_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_note_on_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op == mnpr_pkg::OP_NOTE_ON |=> state_q == mnpr_pkg::ST_DELIVER)
    else $error("note-on did not go straight to delivery");

  a_vel_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mnpr_pkg::ST_VEL |-> $past(hit))
    else $error("velocity read without a held hit");

  a_deliver_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deliver_go |=> out_valid_q && state_q == mnpr_pkg::ST_IDLE)
    else $error("result not loaded into output register");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != mnpr_pkg::ST_IDLE |-> !in_ready_o)
    else $error("item accepted while a search is running");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < mnpr_pkg::RECENT_DEPTH)
    else $error("ring pointer out of range");

endmodule

[rtl/mono_note_priority_retrigger_top.sv]
// Monophonic note priority engine. Each item (note on, note off, all notes
// off) gives exactly one result. Note-on and all-notes-off go straight to
// delivery. A note-off with highest or lowest priority walks the held flags
// one note per cycle; with latest priority (or retrigger off) it walks the
// recent-note ring memory, reading and then checking each entry. A found
// note costs one more read of the velocity memory. The result sits in an
// output register, so the next item is taken while it waits. No clearing
// pass after reset: per-entry flags mark held notes and written ring slots.
module mono_note_priority_retrigger_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mnpr_pkg::OP_W-1:0]         op_i,
  input  logic [mnpr_pkg::NOTE_W-1:0]       note_number_i,
  input  logic [mnpr_pkg::VEL_W-1:0]        note_velocity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              sounds_o,
  output logic [mnpr_pkg::NOTE_W-1:0]       note_out_o,
  output logic [mnpr_pkg::VEL_W-1:0]        velocity_out_o,
  output logic                              fire_trigger_o,
  output logic                              gate_high_o,
  output logic                              gate_low_o,
  input  logic                              cfg_we_i,
  input  logic [mnpr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mnpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  mnpr_pkg::retrig_e            retrig_q;
  mnpr_pkg::trig_e              trig_q;

  mnpr_pkg::held_wr_t           held_wr;
  logic                         held_clear;
  logic [mnpr_pkg::HELD_AW-1:0] held_raddr;
  logic                         held;
  logic [mnpr_pkg::VEL_W-1:0]   held_rdata;
  mnpr_pkg::ring_wr_t           ring_wr;
  logic [mnpr_pkg::RING_AW-1:0] ring_raddr;
  logic [mnpr_pkg::NOTE_W-1:0]  ring_data;
  mnpr_pkg::res_t               res;

  // configuration registers; trigger code three behaves as no trigger
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retrig_q <= mnpr_pkg::RT_OFF;
      trig_q   <= mnpr_pkg::TRIG_PULSE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mnpr_pkg::CFG_RETRIGGER: retrig_q <= mnpr_pkg::retrig_e'(cfg_data_i);
        mnpr_pkg::CFG_TRIGGER:   trig_q   <= mnpr_pkg::trig_e'(cfg_data_i);
      endcase
    end
  end

  // velocity per note plus held flags
  mnpr_held_mem u_held (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (held_wr),
    .clear_all_i (held_clear),
    .raddr_i     (held_raddr),
    .held_o      (held),
    .rdata_o     (held_rdata)
  );

  // ring of recent note-ons, used by latest priority and by retrigger off
  mnpr_ring_mem u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ring_wr),
    .raddr_i (ring_raddr),
    .rdata_o (ring_data)
  );

  // sequencer: updates, searches and result register
  mnpr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .note_number_i   (note_number_i),
    .note_velocity_i (note_velocity_i),
    .retrig_i        (retrig_q),
    .trig_i          (trig_q),
    .held_wr_o       (held_wr),
    .held_clear_o    (held_clear),
    .held_raddr_o    (held_raddr),
    .held_i          (held),
    .held_rdata_i    (held_rdata),
    .ring_wr_o       (ring_wr),
    .ring_raddr_o    (ring_raddr),
    .ring_data_i     (ring_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .res_o           (res)
  );

  assign sounds_o       = res.sounds;
  assign note_out_o     = res.note;
  assign velocity_out_o = res.velocity;
  assign fire_trigger_o = res.fire_trigger;
  assign gate_high_o    = res.gate_high;
  assign gate_low_o     = res.gate_low;

endmodule

[verif/mnpr_note_checker.sv]
module mnpr_note_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [mnpr_pkg::OP_W-1:0]       op_i,
  input  logic [mnpr_pkg::NOTE_W-1:0]     note_number_i,
  input  logic [mnpr_pkg::VEL_W-1:0]      note_velocity_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            sounds_i,
  input  logic [mnpr_pkg::NOTE_W-1:0]     note_out_i,
  input  logic [mnpr_pkg::VEL_W-1:0]      velocity_out_i,
  input  logic                            fire_trigger_i,
  input  logic                            gate_high_i,
  input  logic                            gate_low_i,
  input  logic                            cfg_we_i,
  input  logic [mnpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mnpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     errors_o,
  output int unsigned                     results_o,
  output int unsigned                     resounds_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [mnpr_pkg::VEL_W-1:0]      held_vel [mnpr_pkg::NOTE_COUNT];
  logic [mnpr_pkg::NOTE_W-1:0]     recent   [mnpr_pkg::RECENT_DEPTH];
  int unsigned                     ring_wp;
  mnpr_pkg::retrig_e               prio_sel;
  logic [mnpr_pkg::CFG_DATA_W-1:0] trig_sel;
  mnpr_pkg::res_t                  predicted_q [$];

  function automatic mnpr_pkg::res_t started_note(input logic [mnpr_pkg::NOTE_W-1:0] note,
                                                  input logic [mnpr_pkg::VEL_W-1:0] vel);
    mnpr_pkg::res_t r;
    r              = '0;
    r.sounds       = 1'b1;
    r.note         = note;
    r.velocity     = vel;
    r.fire_trigger = (trig_sel == mnpr_pkg::TRIG_PULSE);
    r.gate_high    = (trig_sel == mnpr_pkg::TRIG_GATE);
    return r;
  endfunction

  // Applies one note event to the held table and ring, returns the note event
  // the block should report for it.
  function automatic mnpr_pkg::res_t play_event(input logic [mnpr_pkg::OP_W-1:0] op,
                                                input logic [mnpr_pkg::NOTE_W-1:0] note,
                                                input logic [mnpr_pkg::VEL_W-1:0] vel);
    mnpr_pkg::res_t r;
    int             found;
    int unsigned    slot;
    r     = '0;
    found = -1;
    case (op)
      mnpr_pkg::OP_NOTE_ON: begin
        recent[ring_wp] = note;
        ring_wp         = (ring_wp + 1) % mnpr_pkg::RECENT_DEPTH;
        if (note < mnpr_pkg::NOTE_COUNT) held_vel[note] = vel;
        r = started_note(note, vel);
      end
      mnpr_pkg::OP_NOTE_OFF: begin
        if (note < mnpr_pkg::NOTE_COUNT) held_vel[note] = '0;
        if (prio_sel == mnpr_pkg::RT_HIGHEST) begin
          for (int i = mnpr_pkg::NOTE_COUNT - 1; i >= 0 && found < 0; i--)
            if (held_vel[i] != '0) found = i;
        end else if (prio_sel == mnpr_pkg::RT_LOWEST) begin
          for (int i = 0; i < mnpr_pkg::NOTE_COUNT && found < 0; i++)
            if (held_vel[i] != '0) found = i;
        end else begin
          // off searches newest-first through the ring, like latest
          for (int i = 0; i < mnpr_pkg::RECENT_DEPTH && found < 0; i++) begin
            slot = (ring_wp + mnpr_pkg::RECENT_DEPTH - 1 - i) % mnpr_pkg::RECENT_DEPTH;
            if (recent[slot] < mnpr_pkg::NOTE_COUNT && held_vel[recent[slot]] != '0)
              found = recent[slot];
          end
        end
        if (found < 0) begin
          r.gate_low = (trig_sel == mnpr_pkg::TRIG_GATE);
        end else if (prio_sel != mnpr_pkg::RT_OFF) begin
          r = started_note(mnpr_pkg::NOTE_W'(found), held_vel[found]);
        end
      end
      mnpr_pkg::OP_ALL_OFF: begin
        foreach (held_vel[i]) held_vel[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mnpr_pkg::res_t got;
    mnpr_pkg::res_t want;
    if (!rst_ni) begin
      foreach (held_vel[i]) held_vel[i] = '0;
      foreach (recent[i]) recent[i] = '0;
      ring_wp     = 0;
      prio_sel    = mnpr_pkg::RT_OFF;
      trig_sel    = mnpr_pkg::TRIG_PULSE;
      predicted_q.delete();
      errors_o    = 0;
      results_o   = 0;
      resounds_o  = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mnpr_pkg::CFG_RETRIGGER) prio_sel = mnpr_pkg::retrig_e'(cfg_data_i);
        else if (cfg_idx_i == mnpr_pkg::CFG_TRIGGER) trig_sel = cfg_data_i;
      end

      if (out_valid_i && out_ready_i) begin
        got.sounds       = sounds_i;
        got.note         = note_out_i;
        got.velocity     = velocity_out_i;
        got.fire_trigger = fire_trigger_i;
        got.gate_high    = gate_high_i;
        got.gate_low     = gate_low_i;
        results_o++;
        if (predicted_q.size() == 0) begin
          $error("result with no item waiting (note_out %0d)", note_out_i);
          errors_o++;
        end else begin
          want = predicted_q.pop_front();
          if (got.sounds !== want.sounds) begin
            $error("sounds: expected %0d, got %0d", want.sounds, got.sounds);
            errors_o++;
          end
          if (got.note !== want.note) begin
            $error("note_out: expected %0d, got %0d", want.note, got.note);
            errors_o++;
          end
          if (got.velocity !== want.velocity) begin
            $error("velocity_out: expected %0d, got %0d", want.velocity, got.velocity);
            errors_o++;
          end
          if (got.fire_trigger !== want.fire_trigger) begin
            $error("fire_trigger: expected %0d, got %0d",
                   want.fire_trigger, got.fire_trigger);
            errors_o++;
          end
          if (got.gate_high !== want.gate_high) begin
            $error("gate_high: expected %0d, got %0d", want.gate_high, got.gate_high);
            errors_o++;
          end
          if (got.gate_low !== want.gate_low) begin
            $error("gate_low: expected %0d, got %0d", want.gate_low, got.gate_low);
            errors_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        want = play_event(op_i, note_number_i, note_velocity_i);
        if (op_i == mnpr_pkg::OP_NOTE_OFF && want.sounds) resounds_o++;
        predicted_q.push_back(want);
      end

      pending_o = predicted_q.size();
    end
  end

endmodule

[verif/mono_note_priority_retrigger_top_tb.sv]
module mono_note_priority_retrigger_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block accepts but the package leaves unnamed
  localparam logic [mnpr_pkg::OP_W-1:0]       OP_SPARE   = 2'd3;  // ignored op, all-zero result
  localparam logic [mnpr_pkg::CFG_DATA_W-1:0] TRIG_SPARE = 2'd3;  // behaves like no trigger

  // A highest/lowest note-off walks the whole held table: allow that plus margin
  localparam int unsigned SETTLE_CYC   = mnpr_pkg::NOTE_COUNT + 12;
  // Long receiver hold-off, started once this many results have been taken
  localparam int unsigned HOLD_OFF_AT  = 80;
  localparam int unsigned HOLD_OFF_CYC = 400;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_EVENTS = 50;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [mnpr_pkg::OP_W-1:0]       op_i;
  logic [mnpr_pkg::NOTE_W-1:0]     note_number_i;
  logic [mnpr_pkg::VEL_W-1:0]      note_velocity_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            sounds_o;
  logic [mnpr_pkg::NOTE_W-1:0]     note_out_o;
  logic [mnpr_pkg::VEL_W-1:0]      velocity_out_o;
  logic                            fire_trigger_o;
  logic                            gate_high_o;
  logic                            gate_low_o;
  logic                            cfg_we_i;
  logic [mnpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mnpr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int unsigned errors;
  int unsigned results_seen;
  int unsigned resounds;
  int unsigned pending;

  // Stimulus bookkeeping; no_gaps is shared by the sender and the receiver
  bit          no_gaps;        // both sides run flat out while set
  int unsigned events_sent;    // items accepted by the block
  int unsigned settings_used;  // mode settings the run went through

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  mono_note_priority_retrigger_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .note_number_i   (note_number_i),
    .note_velocity_i (note_velocity_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sounds_o        (sounds_o),
    .note_out_o      (note_out_o),
    .velocity_out_o  (velocity_out_o),
    .fire_trigger_o  (fire_trigger_o),
    .gate_high_o     (gate_high_o),
    .gate_low_o      (gate_low_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Predicts and checks every item and result seen on the two channels
  mnpr_note_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .note_number_i   (note_number_i),
    .note_velocity_i (note_velocity_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sounds_i        (sounds_o),
    .note_out_i      (note_out_o),
    .velocity_out_i  (velocity_out_o),
    .fire_trigger_i  (fire_trigger_o),
    .gate_high_i     (gate_high_o),
    .gate_low_i      (gate_low_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .errors_o        (errors),
    .results_o       (results_seen),
    .resounds_o      (resounds),
    .pending_o       (pending)
  );

  // Offers one item after a random gap and returns at the edge it is taken.
  // Valid is left high so a back-to-back item needs no second assignment in
  // the same step; whoever stops sending lowers it.
  task automatic offer_event(input logic [mnpr_pkg::OP_W-1:0]   op,
                             input logic [mnpr_pkg::NOTE_W-1:0] note,
                             input logic [mnpr_pkg::VEL_W-1:0]  vel);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    note_number_i   <= note;
    note_velocity_i <= vel;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    events_sent++;
  endtask

  // Mode change: only once every result is home and the block has settled
  task automatic apply_modes(input logic [mnpr_pkg::CFG_DATA_W-1:0] retrig,
                             input logic [mnpr_pkg::CFG_DATA_W-1:0] trig);
    in_valid_i <= 1'b0;
    wait (results_seen == events_sent);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mnpr_pkg::CFG_RETRIGGER;
    cfg_data_i <= retrig;
    @(posedge clk_i);
    cfg_idx_i  <= mnpr_pkg::CFG_TRIGGER;
    cfg_data_i <= trig;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random stall per result, one long hold-off so the output
  // register fills and in_ready drops while the sender keeps offering.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    out_ready_i <= 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYC;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      taken++;
    end
  end

  initial begin : stimulus
    logic [mnpr_pkg::OP_W-1:0]       op;
    logic [mnpr_pkg::NOTE_W-1:0]     note;
    logic [mnpr_pkg::NOTE_W-1:0]     base;
    logic [mnpr_pkg::VEL_W-1:0]      vel;
    logic [mnpr_pkg::CFG_DATA_W-1:0] retrig;
    logic [mnpr_pkg::CFG_DATA_W-1:0] trig;
    int unsigned                     pick;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    op_i            <= mnpr_pkg::OP_NOTE_ON;
    note_number_i   <= '0;
    note_velocity_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= mnpr_pkg::CFG_RETRIGGER;
    cfg_data_i      <= '0;
    no_gaps         = 1'b0;
    events_sent     = 0;
    settings_used   = 1;  // the reset modes count as the first setting
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // Reset modes: retrigger off, pulse trigger
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd0, 7'd127);    // lowest note, loudest
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd127, 7'd1);    // highest note, softest held
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd64, 7'd0);     // zero velocity: sounds, not held
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd127, 7'd0);   // retrigger off: nothing re-sounds
    offer_event(OP_SPARE, 7'd127, 7'd127);              // unused op: no effect
    offer_event(mnpr_pkg::OP_ALL_OFF, 7'd0, 7'd0);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd0, 7'd0);     // nothing held, pulse mode

    // Highest priority in gate mode: walk down then gate low
    apply_modes(mnpr_pkg::RT_HIGHEST, mnpr_pkg::TRIG_GATE);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd10, 7'd50);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd100, 7'd60);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd127, 7'd127);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd127, 7'd0);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd100, 7'd0);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd10, 7'd0);    // last one out: gate low

    // Retrigger off still drops the gate when nothing is left
    apply_modes(mnpr_pkg::RT_OFF, mnpr_pkg::TRIG_GATE);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd5, 7'd3);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd5, 7'd0);

    // Lowest priority with the spare trigger mode (no trigger output)
    apply_modes(mnpr_pkg::RT_LOWEST, TRIG_SPARE);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd0, 7'd1);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd1, 7'd2);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd127, 7'd0);   // off for a note not held
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd0, 7'd0);

    // Latest priority, no trigger output; all-off keeps the ring
    apply_modes(mnpr_pkg::RT_LATEST, mnpr_pkg::TRIG_NONE);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd30, 7'd9);
    offer_event(mnpr_pkg::OP_NOTE_ON, 7'd20, 7'd8);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd20, 7'd0);
    offer_event(mnpr_pkg::OP_ALL_OFF, 7'd0, 7'd0);
    offer_event(mnpr_pkg::OP_NOTE_OFF, 7'd30, 7'd0);

    // --- random part ---
    // The first eight phases step through every retrigger and trigger mode,
    // the spare trigger code included; the last two draw modes at random.
    // Notes mostly come from a 16-note window so offs hit held notes and the
    // ring wraps with live entries in it.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 8) begin
        retrig = mnpr_pkg::CFG_DATA_W'(ph % 4);
        trig   = mnpr_pkg::CFG_DATA_W'((ph + ph / 4) % 4);
      end else begin
        retrig = mnpr_pkg::CFG_DATA_W'($urandom_range(0, 3));
        trig   = mnpr_pkg::CFG_DATA_W'($urandom_range(0, 3));
      end
      apply_modes(retrig, trig);
      no_gaps = (ph % 3 == 2);
      base    = mnpr_pkg::NOTE_W'($urandom_range(0, mnpr_pkg::NOTE_COUNT - 16));
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = mnpr_pkg::OP_NOTE_ON;
        else if (pick < 94) op = mnpr_pkg::OP_NOTE_OFF;
        else if (pick < 97) op = mnpr_pkg::OP_ALL_OFF;
        else                op = OP_SPARE;
        if ($urandom_range(0, 4) == 0) note = mnpr_pkg::NOTE_W'($urandom_range(0, 127));
        else                           note = base + mnpr_pkg::NOTE_W'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) vel = '0;
        else                           vel = mnpr_pkg::VEL_W'($urandom_range(1, 127));
        offer_event(op, note, vel);
      end
    end
    no_gaps = 1'b0;

    // Drain, then give the block time to show any stray result
    in_valid_i <= 1'b0;
    wait (results_seen == events_sent);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("Covered %0d note events over %0d mode settings, all ops and modes.",
             events_sent, settings_used);
    $display("Checked %0d results, %0d of them note-offs re-sounding a held note.",
             results_seen, resounds);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
